### design/rdz_pkg.sv
// Package: shared types, constants and a helper function of the radial dead zone shaper.
`timescale 1ns / 1ps
package rdz_pkg;

    // Square-root unit: 62-bit radicand, one result bit per stage.
    localparam int SQ_BITS   = 31;
    localparam int SQ_RAD_W  = 2 * SQ_BITS;
    // Divider unit: 48-bit dividend, 24-bit divisor, an overflow stage, then one quotient bit per stage.
    localparam int DIV_Q     = 24;
    localparam int DIV_NUM_W = 2 * DIV_Q;
    // Power curve: integer multiplies and fractional root rounds.
    localparam int CRV_INT   = 15;
    localparam int CRV_FRAC  = 12;

    localparam logic [15:0] T_ONE      = 16'd32768;
    localparam logic [15:0] EXP_LINEAR = 16'd4096;
    localparam logic [30:0] ACC_ONE    = 31'h4000_0000;
    localparam logic signed [23:0] OUT_MAX = 24'sh7F_FFFF;
    localparam logic signed [23:0] OUT_MIN = -24'sh80_0000;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_DEAD_ZONE = 2'd0,
        CFG_SAT_POINT = 2'd1,
        CFG_SCALE     = 2'd2,
        CFG_EXPONENT  = 2'd3
    } t_cfg_idx;

    // Everything a sample carries down the pipeline.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               dz;
        logic [23:0]        mag;
        logic [15:0]        t;
        logic [30:0]        acc;
        logic [30:0]        root;
        logic signed [31:0] gain;
        logic signed [23:0] sx;
    } t_item;

    // Signed result from an unsigned quotient with overflow, saturated to 24 bits.
    function automatic logic signed [23:0] f_sat(input logic [23:0] q, input logic ovf,
                                                 input logic neg);
        logic signed [23:0] v;
        v = signed'(q);
        if (ovf || q[23]) begin
            return neg ? OUT_MIN : OUT_MAX;
        end
        return neg ? -v : v;
    endfunction

endpackage

### design/rdz_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a sample riding alongside.
`timescale 1ns / 1ps
module rdz_sqrt
    import rdz_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_item               i_item,
    input  logic [SQ_RAD_W-1:0] i_rad,
    output logic                o_valid,
    output t_item               o_item,
    output logic [SQ_BITS-1:0]  o_root
);

    logic [SQ_RAD_W-1:0] w_rem  [0:SQ_BITS];
    logic [SQ_BITS-1:0]  w_res  [0:SQ_BITS];
    t_item               w_item [0:SQ_BITS];
    logic                w_v    [0:SQ_BITS];

    assign w_rem[0]  = i_rad;
    assign w_res[0]  = '0;
    assign w_item[0] = i_item;
    assign w_v[0]    = i_valid;

    for (genvar s = 0; s < SQ_BITS; s++) begin : g_stage
        localparam int I = SQ_BITS - 1 - s;
        logic [SQ_RAD_W:0]   trial;
        logic                take;
        logic [SQ_RAD_W-1:0] r_rem, n_rem;
        logic [SQ_BITS-1:0]  r_res, n_res;
        t_item               r_item;
        logic                r_v;

        // Try setting result bit I: (r + 2^I)^2 - r^2 = r * 2^(I+1) + 2^(2I).
        assign trial = ({{(SQ_BITS + 1){1'b0}}, w_res[s]} << (I + 1))
                     + ((SQ_RAD_W + 1)'(1) << (2 * I));
        assign take  = {1'b0, w_rem[s]} >= trial;

        always_comb begin
            n_rem = w_rem[s];
            n_res = w_res[s];
            if (take) begin
                n_rem = w_rem[s] - trial[SQ_RAD_W-1:0];
                n_res = w_res[s] | (SQ_BITS'(1) << I);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[s];
            end
            if (i_en) begin
                r_rem  <= n_rem;
                r_res  <= n_res;
                r_item <= w_item[s];
            end
        end

        assign w_rem[s+1]  = r_rem;
        assign w_res[s+1]  = r_res;
        assign w_item[s+1] = r_item;
        assign w_v[s+1]    = r_v;
    end

    assign o_valid = w_v[SQ_BITS];
    assign o_item  = w_item[SQ_BITS];
    assign o_root  = w_res[SQ_BITS];

endmodule

### design/rdz_div.sv
// Pipelined restoring divider with overflow detection and a sample riding alongside.
`timescale 1ns / 1ps
module rdz_div
    import rdz_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_item                i_item,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_Q-1:0]     i_den,
    output logic                 o_valid,
    output t_item                o_item,
    output logic [DIV_Q-1:0]     o_quo,
    output logic                 o_ovf
);

    logic [DIV_NUM_W-1:0] w_rem  [0:DIV_Q+1];
    logic [DIV_Q-1:0]     w_den  [0:DIV_Q+1];
    logic [DIV_Q-1:0]     w_quo  [0:DIV_Q+1];
    logic                 w_ovf  [0:DIV_Q+1];
    t_item                w_item [0:DIV_Q+1];
    logic                 w_v    [0:DIV_Q+1];

    assign w_rem[0]  = i_num;
    assign w_den[0]  = i_den;
    assign w_quo[0]  = '0;
    assign w_ovf[0]  = 1'b0;
    assign w_item[0] = i_item;
    assign w_v[0]    = i_valid;

    for (genvar s = 0; s <= DIV_Q; s++) begin : g_stage
        logic [DIV_NUM_W-1:0] r_rem, n_rem;
        logic [DIV_Q-1:0]     r_den;
        logic [DIV_Q-1:0]     r_quo, n_quo;
        logic                 r_ovf, n_ovf;
        t_item                r_item;
        logic                 r_v;

        if (s == 0) begin : g_ovf
            // The quotient does not fit when the dividend reaches den * 2^DIV_Q.
            always_comb begin
                n_rem = w_rem[s];
                n_quo = w_quo[s];
                n_ovf = w_rem[s] >= {w_den[s], {DIV_Q{1'b0}}};
            end
        end else begin : g_bit
            localparam int I = DIV_Q - s;
            logic [DIV_NUM_W-1:0] sub;
            assign sub = {{DIV_Q{1'b0}}, w_den[s]} << I;
            always_comb begin
                n_rem = w_rem[s];
                n_quo = w_quo[s];
                n_ovf = w_ovf[s];
                if (w_rem[s] >= sub) begin
                    n_rem = w_rem[s] - sub;
                    n_quo = w_quo[s] | (DIV_Q'(1) << I);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[s];
            end
            if (i_en) begin
                r_rem  <= n_rem;
                r_den  <= w_den[s];
                r_quo  <= n_quo;
                r_ovf  <= n_ovf;
                r_item <= w_item[s];
            end
        end

        assign w_rem[s+1]  = r_rem;
        assign w_den[s+1]  = r_den;
        assign w_quo[s+1]  = r_quo;
        assign w_ovf[s+1]  = r_ovf;
        assign w_item[s+1] = r_item;
        assign w_v[s+1]    = r_v;
    end

    assign o_valid = w_v[DIV_Q+1];
    assign o_item  = w_item[DIV_Q+1];
    assign o_quo   = w_quo[DIV_Q+1];
    assign o_ovf   = w_ovf[DIV_Q+1];

endmodule

### design/rdz_curve.sv
// Power curve pipeline: integer powers by repeated multiply, fractional powers by chained roots.
`timescale 1ns / 1ps
module rdz_curve
    import rdz_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [15:0] i_exponent,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_valid,
    output t_item       o_item
);

    logic [3:0] w_n;
    assign w_n = i_exponent[15:12];

    t_item w_mit [0:CRV_INT];
    logic  w_mv  [0:CRV_INT];
    assign w_mit[0] = i_item;
    assign w_mv[0]  = i_valid;

    // Integer part: acc = acc * base >> 30 for the first n stages; base sits in root.
    for (genvar k = 0; k < CRV_INT; k++) begin : g_int
        logic [61:0] prod;
        t_item       r_item, n_item;
        logic        r_v;

        assign prod = w_mit[k].acc * w_mit[k].root;

        always_comb begin
            n_item = w_mit[k];
            if (4'(k) < w_n) begin
                n_item.acc = prod[60:30];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_mv[k];
            end
            if (i_en) begin
                r_item <= n_item;
            end
        end

        assign w_mit[k+1] = r_item;
        assign w_mv[k+1]  = r_v;
    end

    t_item w_rit [0:CRV_FRAC];
    logic  w_rv  [0:CRV_FRAC];
    assign w_rit[0] = w_mit[CRV_INT];
    assign w_rv[0]  = w_mv[CRV_INT];

    // Fractional part: each round takes one more square root and applies it if its bit is set.
    for (genvar j = 0; j < CRV_FRAC; j++) begin : g_frac
        t_item              sq_item;
        logic               sq_v;
        logic [SQ_BITS-1:0] sq_root;
        logic [61:0]        prod;
        t_item              r_item, n_item;
        logic               r_v;

        rdz_sqrt u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_rv[j]),
            .i_item  (w_rit[j]),
            .i_rad   ({1'b0, w_rit[j].root, 30'd0}),
            .o_valid (sq_v),
            .o_item  (sq_item),
            .o_root  (sq_root)
        );

        assign prod = sq_item.acc * sq_root;

        always_comb begin
            n_item      = sq_item;
            n_item.root = sq_root;
            if (i_exponent[CRV_FRAC-1-j]) begin
                n_item.acc = prod[60:30];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= sq_v;
            end
            if (i_en) begin
                r_item <= n_item;
            end
        end

        assign w_rit[j+1] = r_item;
        assign w_rv[j+1]  = r_v;
    end

    assign o_valid = w_rv[CRV_FRAC];
    assign o_item  = w_rit[CRV_FRAC];

endmodule

### design/radial_deadzone_response_curve.sv
// Top level: radial dead zone with power response curve, fully pipelined.
//
//  Channel   Direction  Handshake            Payload
//  input     in         i_valid / o_ready    i_axis_x, i_axis_y
//  output    out        o_valid / i_ready    o_shaped_x, o_shaped_y, o_in_dead_zone
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One request is taken per cycle while the output side keeps up. The latency is set
// mostly by the twelve chained 31-stage square-root pipelines of the curve unit, plus
// one magnitude root and three 25-stage dividers.
// Reset is synchronous, clears all valid bits and loads the configuration defaults.
// A stall on the output freezes the whole pipeline in place; nothing is lost or repeated.
`timescale 1ns / 1ps
module radial_deadzone_response_curve
    import rdz_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_axis_x,
    input  logic signed [15:0] i_axis_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [23:0] o_shaped_x,
    output logic signed [23:0] o_shaped_y,
    output logic               o_in_dead_zone,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);

    logic [14:0]        r_dead_zone;
    logic [14:0]        r_sat_point;
    logic signed [15:0] r_scale;
    logic [15:0]        r_exponent;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= 15'd3277;
            r_sat_point <= 15'd32767;
            r_scale     <= 16'sd256;
            r_exponent  <= EXP_LINEAR;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DEAD_ZONE: r_dead_zone <= i_cfg_data[14:0];
                CFG_SAT_POINT: r_sat_point <= i_cfg_data[14:0];
                CFG_SCALE:     r_scale     <= signed'(i_cfg_data);
                CFG_EXPONENT:  r_exponent  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together unless the output holds a result not yet taken.
    logic w_en;
    logic r_h_v;
    assign w_en    = !r_h_v || i_ready;
    assign o_ready = w_en;

    // Stage A: squares of both axes.
    logic               r_a_v;
    logic signed [15:0] r_a_x, r_a_y;
    logic [30:0]        r_a_xx, r_a_yy;
    logic signed [31:0] w_xx, w_yy;
    assign w_xx = i_axis_x * i_axis_x;
    assign w_yy = i_axis_y * i_axis_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_valid;
        end
        if (w_en) begin
            r_a_x  <= i_axis_x;
            r_a_y  <= i_axis_y;
            r_a_xx <= w_xx[30:0];
            r_a_yy <= w_yy[30:0];
        end
    end

    // Stage B: squared magnitude and exact dead zone test.
    logic                r_b_v;
    t_item               r_b_item, n_b_item;
    logic [SQ_RAD_W-1:0] r_b_rad;
    logic [31:0]         w_sum;
    logic [29:0]         w_dz_sq;
    assign w_sum   = {1'b0, r_a_xx} + {1'b0, r_a_yy};
    assign w_dz_sq = r_dead_zone * r_dead_zone;

    always_comb begin
        n_b_item    = '0;
        n_b_item.x  = r_a_x;
        n_b_item.y  = r_a_y;
        n_b_item.dz = w_sum <= {2'b00, w_dz_sq};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_b_v <= r_a_v;
        end
        if (w_en) begin
            r_b_item <= n_b_item;
            r_b_rad  <= {14'd0, w_sum, 16'd0};
        end
    end

    // Magnitude root.
    logic               w_m_v;
    t_item              w_m_item;
    logic [SQ_BITS-1:0] w_m_root;

    rdz_sqrt u_mag_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_b_v),
        .i_item  (r_b_item),
        .i_rad   (r_b_rad),
        .o_valid (w_m_v),
        .o_item  (w_m_item),
        .o_root  (w_m_root)
    );

    // Stage C: deflection beyond the dead zone, set up for normalising.
    logic                 r_c_v;
    t_item                r_c_item, n_c_item;
    logic [DIV_NUM_W-1:0] r_c_num;
    logic [DIV_Q-1:0]     r_c_den;
    logic [23:0]          w_mag, w_dz_m, w_over;
    assign w_mag  = w_m_root[23:0];
    assign w_dz_m = {1'b0, r_dead_zone, 8'd0};
    assign w_over = (w_mag > w_dz_m) ? (w_mag - w_dz_m) : 24'd0;

    always_comb begin
        n_c_item     = w_m_item;
        n_c_item.mag = w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en) begin
            r_c_v <= w_m_v;
        end
        if (w_en) begin
            r_c_item <= n_c_item;
            r_c_num  <= {17'd0, w_over, 7'd0};
            r_c_den  <= {9'd0, 15'(r_sat_point - r_dead_zone)};
        end
    end

    logic             w_n_v;
    t_item            w_n_item;
    logic [DIV_Q-1:0] w_n_quo;
    logic             w_n_ovf;

    rdz_div u_norm_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_v),
        .i_item  (r_c_item),
        .i_num   (r_c_num),
        .i_den   (r_c_den),
        .o_valid (w_n_v),
        .o_item  (w_n_item),
        .o_quo   (w_n_quo),
        .o_ovf   (w_n_ovf)
    );

    // Stage D: clamp the normalised deflection to one and seed the power curve.
    logic  r_d_v;
    t_item r_d_item, n_d_item;
    logic  w_t_full;
    assign w_t_full = (r_sat_point <= r_dead_zone) || w_n_ovf
                   || (w_n_quo > {8'd0, T_ONE});

    always_comb begin
        n_d_item      = w_n_item;
        n_d_item.t    = w_t_full ? T_ONE : w_n_quo[15:0];
        n_d_item.acc  = ACC_ONE;
        n_d_item.root = {n_d_item.t, 15'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (w_en) begin
            r_d_v <= w_n_v;
        end
        if (w_en) begin
            r_d_item <= n_d_item;
        end
    end

    logic  w_p_v;
    t_item w_p_item;

    rdz_curve u_curve (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_exponent (r_exponent),
        .i_valid    (r_d_v),
        .i_item     (r_d_item),
        .o_valid    (w_p_v),
        .o_item     (w_p_item)
    );

    // Stage E: pick the curved or linear value and apply the gain.
    logic               r_e_v;
    t_item              r_e_item, n_e_item;
    logic [15:0]        w_tc;
    logic signed [32:0] w_gain;
    assign w_tc   = (r_exponent == EXP_LINEAR) ? w_p_item.t : w_p_item.acc[30:15];
    assign w_gain = signed'({1'b0, w_tc}) * r_scale;

    always_comb begin
        n_e_item      = w_p_item;
        n_e_item.gain = w_gain[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (w_en) begin
            r_e_v <= w_p_v;
        end
        if (w_en) begin
            r_e_item <= n_e_item;
        end
    end

    // Stage F: |x| * |gain| for the horizontal component.
    logic                 r_f_v;
    t_item                r_f_item;
    logic [DIV_NUM_W-1:0] r_f_num;
    logic [30:0]          w_ua;
    logic [15:0]          w_ux;
    logic [46:0]          w_px;
    assign w_ua = r_e_item.gain[31] ? 31'(-r_e_item.gain) : r_e_item.gain[30:0];
    assign w_ux = r_e_item.x[15] ? 16'(-r_e_item.x) : r_e_item.x;
    assign w_px = w_ux * w_ua;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_f_v <= r_e_v;
        end
        if (w_en) begin
            r_f_item <= r_e_item;
            r_f_num  <= {1'b0, w_px};
        end
    end

    logic             w_qx_v;
    t_item            w_qx_item;
    logic [DIV_Q-1:0] w_qx_quo;
    logic             w_qx_ovf;

    rdz_div u_x_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_f_v),
        .i_item  (r_f_item),
        .i_num   (r_f_num),
        .i_den   (r_f_item.mag),
        .o_valid (w_qx_v),
        .o_item  (w_qx_item),
        .o_quo   (w_qx_quo),
        .o_ovf   (w_qx_ovf)
    );

    // Stage G: finish the horizontal component and start the vertical one.
    logic                 r_g_v;
    t_item                r_g_item, n_g_item;
    logic [DIV_NUM_W-1:0] r_g_num;
    logic [30:0]          w_ga;
    logic [15:0]          w_uy;
    logic [46:0]          w_py;
    assign w_ga = w_qx_item.gain[31] ? 31'(-w_qx_item.gain) : w_qx_item.gain[30:0];
    assign w_uy = w_qx_item.y[15] ? 16'(-w_qx_item.y) : w_qx_item.y;
    assign w_py = w_uy * w_ga;

    always_comb begin
        n_g_item    = w_qx_item;
        n_g_item.sx = f_sat(w_qx_quo, w_qx_ovf, w_qx_item.x[15] != w_qx_item.gain[31]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (w_en) begin
            r_g_v <= w_qx_v;
        end
        if (w_en) begin
            r_g_item <= n_g_item;
            r_g_num  <= {1'b0, w_py};
        end
    end

    logic             w_qy_v;
    t_item            w_qy_item;
    logic [DIV_Q-1:0] w_qy_quo;
    logic             w_qy_ovf;

    rdz_div u_y_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_g_v),
        .i_item  (r_g_item),
        .i_num   (r_g_num),
        .i_den   (r_g_item.mag),
        .o_valid (w_qy_v),
        .o_item  (w_qy_item),
        .o_quo   (w_qy_quo),
        .o_ovf   (w_qy_ovf)
    );

    // Stage H: output register; the dead zone forces both components to zero.
    logic signed [23:0] r_h_sx, r_h_sy;
    logic               r_h_dz;
    logic signed [23:0] w_sy;
    assign w_sy = f_sat(w_qy_quo, w_qy_ovf, w_qy_item.y[15] != w_qy_item.gain[31]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else if (w_en) begin
            r_h_v <= w_qy_v;
        end
        if (w_en) begin
            r_h_dz <= w_qy_item.dz;
            r_h_sx <= w_qy_item.dz ? 24'sd0 : w_qy_item.sx;
            r_h_sy <= w_qy_item.dz ? 24'sd0 : w_sy;
        end
    end

    assign o_valid        = r_h_v;
    assign o_shaped_x     = r_h_sx;
    assign o_shaped_y     = r_h_sy;
    assign o_in_dead_zone = r_h_dz;

    // A dead zone result always carries zero components.
    a_dz_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_in_dead_zone |-> o_shaped_x == 24'sd0 && o_shaped_y == 24'sd0)
        else $error("dead zone result with non-zero component");

    // A result waiting at the output blocks new requests.
    a_stall_blocks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("request taken while the output is stalled");

    // No result straight after reset.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

endmodule
